[design/trm_pkg.sv]
// trm_pkg: shared types, codes and default sizes for the token ring membership unit
// depends on nothing; imported by trm_cell, token_ring_membership_unit, trm_checker and testbench
`timescale 1ns / 1ps

package trm_pkg;

	// fixed field widths of the item ports
	localparam int ID_FIELD_W     = 16;
	localparam int ACTION_W       = 2;
	localparam int STATUS_W       = 2;
	localparam int COUNT_FIELD_W  = 5;

	// default sizes
	localparam int DEF_RING_DEPTH = 16;
	localparam int DEF_ID_BITS    = 16;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PASS   = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	// commands broadcast to every cell of the row
	typedef struct packed {
		logic cmp_en;   // latch compare result against the incoming key
		logic ins_en;   // tail cell loads the new station
		logic del_en;   // cells at or behind the first hit take their neighbor's id
	} cell_ctl_t;

endpackage

[design/token_ring_membership_unit.sv]
// token_ring_membership_unit: logical ring of stations with a single token holder
// depends on trm_pkg and trm_cell
//
//  channel | valid     | stall     | fields
//  --------+-----------+-----------+-----------------------------------------------
//  command | cmd_valid | cmd_stall | action, station_id
//  result  | rsp_valid | rsp_stall | status, holder_valid, holder_id, ring_count
//
// For each item the accept edge latches the compare in every cell; a later
// edge, once no result is stalled, applies the shift/insert and loads the
// result register: one compare stage and one update stage in the row of cells.
// Reset clears the count, token and result valid; no clearing pass is needed.
// The update waits while a result is stalled, so ring state is frozen while a
// result is shown; no new item is accepted during that wait.
`timescale 1ns / 1ps

module token_ring_membership_unit import trm_pkg::*; #(
	parameter int RING_DEPTH = DEF_RING_DEPTH,
	parameter int ID_BITS    = DEF_ID_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic [ACTION_W-1:0]      action,
	input  logic [ID_FIELD_W-1:0]    station_id,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [STATUS_W-1:0]      status,
	output logic                     holder_valid,
	output logic [ID_FIELD_W-1:0]    holder_id,
	output logic [COUNT_FIELD_W-1:0] ring_count
);

	localparam int SW = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int TW = $clog2(RING_DEPTH);

	logic                busy_q;
	logic [ACTION_W-1:0] action_q;
	logic [SW-1:0]       id_q;
	logic [CW-1:0]       count_q;
	logic [TW-1:0]       tok_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;

	logic                cmd_accept;
	logic                upd_fire;
	logic [SW-1:0]       key;
	cell_ctl_t           ctl;

	logic [RING_DEPTH:0]   carry;
	logic [RING_DEPTH-1:0] first_hit;
	logic [SW-1:0]         cell_id [RING_DEPTH];

	logic                found;
	logic                hit_lt_tok;
	logic                hit_eq_tok;
	logic [CW-1:0]       cnt_dec;
	logic [CW-1:0]       tok_inc;
	logic [CW-1:0]       count_d;
	logic [TW-1:0]       tok_d;
	logic [STATUS_W-1:0] status_d;
	logic                ins_ok;
	logic                del_ok;

	// handshakes
	assign cmd_accept = cmd_valid & ~cmd_stall;
	assign cmd_stall  = busy_q;
	assign upd_fire   = busy_q & (~rsp_valid_q | ~rsp_stall);
	assign key        = station_id[SW-1:0];

	// broadcast commands for the row
	always_comb begin
		ctl        = '0;
		ctl.cmp_en = cmd_accept;
		ctl.ins_en = upd_fire & ins_ok;
		ctl.del_en = upd_fire & del_ok;
	end

	// the row of cells
	assign carry[0] = 1'b0;
	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		logic [SW-1:0] nxt;
		if (i == RING_DEPTH - 1) begin : g_last
			assign nxt = cell_id[i];
		end else begin : g_mid
			assign nxt = cell_id[i+1];
		end
		trm_cell #(
			.ID_W(SW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.in_ring  (CW'(i) < count_q),
			.is_tail  (CW'(i) == count_q),
			.key      (key),
			.ins_id   (id_q),
			.nxt_id   (nxt),
			.carry_in (carry[i]),
			.carry_out(carry[i+1]),
			.first_hit(first_hit[i]),
			.id_out   (cell_id[i])
		);
	end

	// where the first hit lies relative to the holder
	assign found      = carry[RING_DEPTH];
	assign hit_lt_tok = carry[tok_q];
	assign hit_eq_tok = first_hit[tok_q];
	assign cnt_dec    = count_q - CW'(1);
	assign tok_inc    = CW'(tok_q) + CW'(1);

	// next count, token and status
	always_comb begin
		count_d  = count_q;
		tok_d    = tok_q;
		status_d = ST_DONE;
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		unique case (action_q)
			ACT_INSERT: begin
				if (count_q >= CW'(RING_DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					ins_ok  = 1'b1;
					count_d = count_q + CW'(1);
					if (count_q == '0) begin
						tok_d = '0;
					end
				end
			end
			ACT_DELETE: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if (!found) begin
					status_d = ST_NOT_FOUND;
				end else begin
					del_ok  = 1'b1;
					count_d = cnt_dec;
					priority if (cnt_dec == '0) begin
						tok_d = '0;
					end else if (hit_lt_tok) begin
						tok_d = tok_q - TW'(1);
					end else if (hit_eq_tok && (CW'(tok_q) >= cnt_dec)) begin
						tok_d = '0;
					end
				end
			end
			ACT_PASS: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if (tok_inc >= count_q) begin
					tok_d = '0;
				end else begin
					tok_d = tok_inc[TW-1:0];
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	// control and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			tok_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_accept) begin
				busy_q <= 1'b1;
			end else if (upd_fire) begin
				busy_q <= 1'b0;
			end
			if (upd_fire) begin
				count_q     <= count_d;
				tok_q       <= tok_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// item payload and result status
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			action_q <= action;
			id_q     <= key;
		end
		if (upd_fire) begin
			status_q <= status_d;
		end
	end

	// result outputs; ring state holds while a result waits
	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign holder_valid = (count_q != '0);
	assign holder_id    = holder_valid ? ID_FIELD_W'(cell_id[tok_q]) : '0;
	assign ring_count   = COUNT_FIELD_W'(count_q);

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RING_DEPTH))
		else $error("ring count above depth");

	a_tok_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(tok_q) < count_q) || (count_q == '0 && tok_q == '0))
		else $error("token position outside ring");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(first_hit))
		else $error("more than one first hit");

	a_upd_result: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> rsp_valid_q)
		else $error("update without result");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> ($stable(count_q) && $stable(tok_q)))
		else $error("ring changed while result stalled");

endmodule

[design/trm_cell.sv]
// trm_cell: one slot of the ring row; holds a station id and its match flag
// depends on trm_pkg (cell_ctl_t)
`timescale 1ns / 1ps

module trm_cell import trm_pkg::*; #(
	parameter int ID_W = DEF_ID_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cell_ctl_t       ctl,
	input  logic            in_ring,
	input  logic            is_tail,
	input  logic [ID_W-1:0] key,
	input  logic [ID_W-1:0] ins_id,
	input  logic [ID_W-1:0] nxt_id,
	input  logic            carry_in,
	output logic            carry_out,
	output logic            first_hit,
	output logic [ID_W-1:0] id_out
);

	logic [ID_W-1:0] id_q;
	logic            match_q;

	// compare against the key when an item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			match_q <= in_ring & (id_q == key);
		end
	end

	// prefix-or of matches travels down the row
	assign carry_out = carry_in | match_q;
	assign first_hit = match_q & ~carry_in;

	// slot contents: move up on delete, load at the tail on insert
	always_ff @(posedge clk) begin
		if (ctl.del_en && carry_out) begin
			id_q <= nxt_id;
		end else if (ctl.ins_en && is_tail) begin
			id_q <= ins_id;
		end
	end

	assign id_out = id_q;

endmodule

[dv/trm_checker.sv]
// trm_checker: watches the command and result channels of the token ring unit,
// keeps its own copy of the ring and compares every result field with the prediction
// depends on trm_pkg
`timescale 1ns / 1ps

module trm_checker import trm_pkg::*; #(
	parameter int RING_DEPTH = DEF_RING_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	input  logic                     cmd_stall,
	input  logic [ACTION_W-1:0]      action,
	input  logic [ID_FIELD_W-1:0]    station_id,
	input  logic                     rsp_valid,
	input  logic                     rsp_stall,
	input  logic [STATUS_W-1:0]      status,
	input  logic                     holder_valid,
	input  logic [ID_FIELD_W-1:0]    holder_id,
	input  logic [COUNT_FIELD_W-1:0] ring_count,
	output int                       fail_count,
	output int                       due_count
);

	typedef struct packed {
		logic [STATUS_W-1:0]      st;
		logic                     hv;
		logic [ID_FIELD_W-1:0]    hid;
		logic [COUNT_FIELD_W-1:0] cnt;
	} ring_reply_t;

	// shadow copy of the ring
	logic [ID_FIELD_W-1:0]         ring_ids [RING_DEPTH];
	logic [COUNT_FIELD_W-1:0]      members;
	logic [$clog2(RING_DEPTH)-1:0] token_idx;

	// replies owed for accepted items, oldest first
	ring_reply_t replies_due[$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (fail_count < 200)
			$display("%0t: mismatch on %s: got %0h, predicted %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// applies one item to the shadow ring and returns the reply it should cause
	function automatic ring_reply_t apply_command(input logic [ACTION_W-1:0] act,
		input logic [ID_FIELD_W-1:0] id);
		ring_reply_t r;
		int hit;
		r.st = ST_DONE;
		case (act)
			ACT_INSERT: begin
				if (members >= RING_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					// first station in an empty ring takes the token
					if (members == 0)
						token_idx = '0;
					ring_ids[members[$clog2(RING_DEPTH)-1:0]] = id;
					members = members + 1'b1;
				end
			end
			ACT_DELETE: begin
				if (members == 0) begin
					r.st = ST_EMPTY;
				end else begin
					hit = -1;
					for (int i = 0; i < members; i++)
						if (hit < 0 && ring_ids[i] == id)
							hit = i;
					if (hit < 0) begin
						r.st = ST_NOT_FOUND;
					end else begin
						// stations behind the hit move up one place
						for (int i = hit; i + 1 < members; i++)
							ring_ids[i] = ring_ids[i + 1];
						members = members - 1'b1;
						if (members == 0)
							token_idx = '0;
						else if (hit < token_idx)
							token_idx = token_idx - 1'b1;
						else if (hit == token_idx && token_idx >= members)
							token_idx = '0;
					end
				end
			end
			ACT_PASS: begin
				if (members == 0)
					r.st = ST_EMPTY;
				else if (int'(token_idx) + 1 >= int'(members))
					token_idx = '0;
				else
					token_idx = token_idx + 1'b1;
			end
			default: ;
		endcase
		r.hv  = (members != 0);
		r.hid = r.hv ? ring_ids[token_idx] : '0;
		r.cnt = members;
		return r;
	endfunction

	// compare accepted results, then predict for accepted items
	always @(posedge clk or negedge arst_n) begin : watch
		ring_reply_t due;
		if (!arst_n) begin
			members    = '0;
			token_idx  = '0;
			replies_due.delete();
			due_count  = 0;
			fail_count = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (replies_due.size() == 0) begin
					report_mismatch("result with none pending", 32'(status), 0);
				end else begin
					due = replies_due.pop_front();
					if (status !== due.st)
						report_mismatch("status", 32'(status), 32'(due.st));
					if (holder_valid !== due.hv)
						report_mismatch("holder_valid", 32'(holder_valid), 32'(due.hv));
					if (holder_id !== due.hid)
						report_mismatch("holder_id", 32'(holder_id), 32'(due.hid));
					if (ring_count !== due.cnt)
						report_mismatch("ring_count", 32'(ring_count), 32'(due.cnt));
				end
			end
			if (cmd_valid && !cmd_stall)
				replies_due.push_back(apply_command(action, station_id));
			due_count = replies_due.size();
		end
	end

endmodule

[dv/testbench.sv]
// testbench: drives directed and random ring commands into token_ring_membership_unit
// with random idling on both channels; trm_checker does the prediction and compare
// depends on trm_pkg, token_ring_membership_unit and trm_checker
`timescale 1ns / 1ps

module testbench import trm_pkg::*; ();

	localparam int LIMIT_CYCLES = 200000;
	localparam int RAND_ITEMS   = 390;
	localparam int CALM_AFTER   = 330;
	localparam int HOLD_AT      = 120;
	localparam int HOLD_CYCLES  = 60;
	localparam int POOL_SIZE    = 12;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     cmd_valid  = 1'b0;
	logic [ACTION_W-1:0]      action     = ACT_NONE;
	logic [ID_FIELD_W-1:0]    station_id = '0;
	logic                     rsp_stall  = 1'b0;
	logic                     cmd_stall;
	logic                     rsp_valid;
	logic [STATUS_W-1:0]      status;
	logic                     holder_valid;
	logic [ID_FIELD_W-1:0]    holder_id;
	logic [COUNT_FIELD_W-1:0] ring_count;

	int fail_count;
	int due_count;
	int items_sent = 0;
	int cycles     = 0;
	bit gaps_on    = 1'b0;
	bit stalls_on  = 1'b0;
	bit held_off   = 1'b0;

	logic [ID_FIELD_W-1:0] id_pool [POOL_SIZE];

	always #5 clk = ~clk;

	token_ring_membership_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.action       (action),
		.station_id   (station_id),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.holder_valid (holder_valid),
		.holder_id    (holder_id),
		.ring_count   (ring_count)
	);

	trm_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.action       (action),
		.station_id   (station_id),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.holder_valid (holder_valid),
		.holder_id    (holder_id),
		.ring_count   (ring_count),
		.fail_count   (fail_count),
		.due_count    (due_count)
	);

	// hang guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("testbench failed");
			$finish;
		end
	end

	// result side: one long hold-off, otherwise random stall bursts
	initial begin : receiver
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && items_sent >= HOLD_AT) begin
				held_off = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp_stall <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// offer one item from a falling edge and hold it until accepted
	task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [ID_FIELD_W-1:0] id);
		action     <= act;
		station_id <= id;
		cmd_valid  <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		items_sent++;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	initial begin : stimulus
		int phase_len;
		int mode;
		int pick;
		logic [ACTION_W-1:0]   act;
		logic [ID_FIELD_W-1:0] id;

		foreach (id_pool[i])
			id_pool[i] = ID_FIELD_W'($urandom);
		id_pool[0] = '0;
		id_pool[1] = '1;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty ring cases, unused code, token wrap, duplicates, deletes
		send_cmd(ACT_PASS,   16'h0000);
		send_cmd(ACT_DELETE, 16'h0005);
		send_cmd(ACT_NONE,   16'hFFFF);
		send_cmd(ACT_INSERT, 16'h0000);
		send_cmd(ACT_PASS,   16'h0000);
		send_cmd(ACT_DELETE, 16'h0000);
		send_cmd(ACT_INSERT, 16'hFFFF);
		send_cmd(ACT_INSERT, 16'h1234);
		send_cmd(ACT_INSERT, 16'hA5A5);
		send_cmd(ACT_INSERT, 16'h1234);
		send_cmd(ACT_PASS,   16'hFFFF);
		send_cmd(ACT_PASS,   16'h0000);
		// delete ahead of the holder
		send_cmd(ACT_DELETE, 16'hFFFF);
		send_cmd(ACT_DELETE, 16'h7777);
		send_cmd(ACT_PASS,   16'h5A5A);
		// duplicate id: first match goes, then the holder at the tail goes
		send_cmd(ACT_DELETE, 16'h1234);
		send_cmd(ACT_DELETE, 16'h1234);
		send_cmd(ACT_PASS,   16'h0000);
		send_cmd(ACT_NONE,   16'h0000);
		send_cmd(ACT_DELETE, 16'hA5A5);

		// random phases that grow, shrink or churn the ring
		while (items_sent < RAND_ITEMS) begin
			mode      = $urandom_range(0, 2);
			phase_len = $urandom_range(15, 50);
			gaps_on   = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
			stalls_on = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
			repeat (phase_len) begin
				// no idling in the last part of the run
				if (items_sent >= CALM_AFTER) begin
					gaps_on   = 1'b0;
					stalls_on = 1'b0;
				end
				pick = $urandom_range(0, 99);
				case (mode)
					0:       act = pick < 60 ? ACT_INSERT : pick < 75 ? ACT_DELETE :
						pick < 95 ? ACT_PASS : ACT_NONE;
					1:       act = pick < 15 ? ACT_INSERT : pick < 70 ? ACT_DELETE :
						pick < 95 ? ACT_PASS : ACT_NONE;
					default: act = pick < 35 ? ACT_INSERT : pick < 65 ? ACT_DELETE :
						pick < 95 ? ACT_PASS : ACT_NONE;
				endcase
				// mostly ids from the pool so deletes find matches
				if ($urandom_range(0, 4) == 0)
					id = ID_FIELD_W'($urandom);
				else
					id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
				send_cmd(act, id);
			end
		end
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		cmd_valid <= 1'b0;

		// drain
		while (due_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0 && due_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
